[hw/rtl/ssaw_pkg.sv]
// Shared types and codes for the session sequencer with ack window.
package ssaw_pkg;

  localparam int unsigned DefWindowBits = 32;
  localparam int unsigned IdW           = 32;
  localparam int unsigned CntW          = 32;
  localparam int unsigned PayW          = 16;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 32;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_SERVER = 2'd1,
    MODE_SEND   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SRV_VERDICT    = 2'd0,
    SRV_DISCONNECT = 2'd1,
    SRV_PONG       = 2'd2,
    SRV_STATS      = 2'd3
  } srv_kind_e;

  typedef enum logic [1:0] {
    MSG_CONNECT    = 2'd0,
    MSG_PING       = 2'd1,
    MSG_STATS      = 2'd2,
    MSG_DISCONNECT = 2'd3
  } msg_kind_e;

  localparam logic [CfgIdxW-1:0] CFG_PING_COUNT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_SIZE = 1'b1;

  // classification of an arriving id against the stored latest id
  typedef struct packed {
    logic late;
    logic newer;
  } id_cls_t;

  typedef struct packed {
    mode_e          mode;
    srv_kind_e      server_kind;
    logic           verdict_ok;
    logic [IdW-1:0] server_msg_id;
  } item_t;

  typedef struct packed {
    logic            msg_valid;
    msg_kind_e       msg_kind;
    logic [IdW-1:0]  msg_id;
    logic [31:0]     ack_bits;
    logic [IdW-1:0]  latest_seen_id;
    logic [PayW-1:0] payload_length;
    logic            session_running;
    logic            session_connected;
    logic [CntW-1:0] sent_total;
    logic [CntW-1:0] received_total;
    logic [CntW-1:0] dropped_total;
    logic [CntW-1:0] late_total;
  } result_t;

endpackage

[hw/rtl/ssaw_window.sv]
// Ack window update and drop count for one arriving server id.
module ssaw_window import ssaw_pkg::*; #(
  parameter int unsigned WindowBits = DefWindowBits
) (
  input  logic [WindowBits-1:0] win_i,
  input  logic [IdW-1:0]        latest_i,
  input  logic [IdW-1:0]        id_i,
  output logic [WindowBits-1:0] win_o,
  output id_cls_t               cls_o,
  output logic [CntW-1:0]       drop_inc_o
);

  localparam int unsigned SW = $clog2(WindowBits + 1);
  localparam int unsigned IW = $clog2(WindowBits);
  localparam logic [IdW-1:0] WinId = IdW'(WindowBits);
  localparam logic [WindowBits-1:0] One = {{(WindowBits-1){1'b0}}, 1'b1};

  function automatic logic [SW-1:0] count_ones(input logic [WindowBits-1:0] v);
    logic [SW-1:0] n;
    n = '0;
    for (int i = 0; i < int'(WindowBits); i++) begin
      n = n + SW'(v[i]);
    end
    return n;
  endfunction

  logic [IdW-1:0]        diff, neg, neg_m1, diff_m1, gap;
  logic [SW-1:0]         top, zeros;
  logic [WindowBits-1:0] top_mask, shifted, late_win, new_win;

  assign diff    = id_i - latest_i;
  assign neg     = '0 - diff;
  assign neg_m1  = neg - 1'b1;
  assign diff_m1 = diff - 1'b1;

  assign cls_o.late  = diff[IdW-1];
  assign cls_o.newer = !diff[IdW-1] && (diff != '0);

  // late: mark bit distance-1 if still inside the window
  assign late_win = (neg <= WinId) ? (win_i | (One << neg_m1[IW-1:0])) : win_i;

  // newer: zeros among the top min(d, W) bits leave the window as drops
  assign top      = (diff < WinId) ? diff[SW-1:0] : SW'(WindowBits);
  assign top_mask = ~({WindowBits{1'b1}} >> top);
  assign zeros    = count_ones(~win_i & top_mask);
  assign gap      = (diff_m1 > WinId) ? (diff_m1 - WinId) : '0;

  assign shifted  = (diff >= WinId) ? '0 : (win_i << diff[SW-1:0]);
  assign new_win  = (diff_m1 < WinId) ? (shifted | (One << diff_m1[IW-1:0])) : shifted;

  always_comb begin
    win_o      = win_i;
    drop_inc_o = '0;
    if (cls_o.late) begin
      win_o = late_win;
    end else if (cls_o.newer) begin
      win_o      = new_win;
      drop_inc_o = CntW'(zeros) + gap;
    end
  end

endmodule

[hw/rtl/ssaw_core.sv]
// Session state, config registers and result formation for one item.
module ssaw_core import ssaw_pkg::*; #(
  parameter int unsigned WindowBits = DefWindowBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                fire_i,
  input  item_t               item_i,
  output result_t             result_o
);

  logic [CntW-1:0] ping_count_q;
  logic [PayW-1:0] payload_size_q;

  logic                  running_q, running_d;
  logic                  connected_q, connected_d;
  logic                  stats_q, stats_d;
  logic [CntW-1:0]       pings_q, pings_d;
  logic [IdW-1:0]        next_id_q, next_id_d;
  logic [IdW-1:0]        latest_q, latest_d;
  logic [WindowBits-1:0] win_q, win_d;
  logic [CntW-1:0]       sent_q, sent_d;
  logic [CntW-1:0]       recv_q, recv_d;
  logic [CntW-1:0]       drop_q, drop_d;
  logic [CntW-1:0]       late_q, late_d;

  logic [WindowBits-1:0] win_next;
  id_cls_t               cls;
  logic [CntW-1:0]       drop_inc;
  logic                  take;
  logic                  msg_valid;
  msg_kind_e             msg_kind;
  logic [IdW-1:0]        msg_id;
  logic [PayW-1:0]       plen;

  ssaw_window #(.WindowBits(WindowBits)) u_window (
    .win_i      (win_q),
    .latest_i   (latest_q),
    .id_i       (item_i.server_msg_id),
    .win_o      (win_next),
    .cls_o      (cls),
    .drop_inc_o (drop_inc)
  );

  always_comb begin
    running_d   = running_q;
    connected_d = connected_q;
    stats_d     = stats_q;
    pings_d     = pings_q;
    next_id_d   = next_id_q;
    latest_d    = latest_q;
    win_d       = win_q;
    sent_d      = sent_q;
    recv_d      = recv_q;
    drop_d      = drop_q;
    late_d      = late_q;
    take        = 1'b0;
    msg_valid   = 1'b0;
    msg_kind    = MSG_CONNECT;
    msg_id      = '0;
    plen        = '0;

    unique case (item_i.mode)
      MODE_START: begin
        pings_d     = ping_count_q;
        connected_d = 1'b0;
        latest_d    = '0;
        win_d       = '1;
        next_id_d   = '0;
        sent_d      = '0;
        recv_d      = '0;
        drop_d      = '0;
        late_d      = '0;
        stats_d     = 1'b1;
        running_d   = 1'b1;
      end
      MODE_SERVER: begin
        unique case (item_i.server_kind)
          SRV_VERDICT: begin
            take = item_i.verdict_ok;
            if (item_i.verdict_ok) begin
              connected_d = 1'b1;
            end else begin
              running_d = 1'b0;
            end
          end
          SRV_DISCONNECT: begin
            running_d   = 1'b0;
            connected_d = 1'b0;
          end
          SRV_PONG: begin
            take = 1'b1;
          end
          SRV_STATS: begin
            stats_d = 1'b0;
            take    = 1'b1;
          end
        endcase
        if (take) begin
          recv_d = recv_q + 1'b1;
          late_d = late_q + CntW'(cls.late);
          drop_d = drop_q + drop_inc;
          win_d  = win_next;
          if (cls.newer) begin
            latest_d = item_i.server_msg_id;
          end
        end
      end
      MODE_SEND: begin
        if (running_q) begin
          msg_valid = 1'b1;
          msg_id    = next_id_q;
          next_id_d = next_id_q + 1'b1;
          sent_d    = sent_q + 1'b1;
          if (!connected_q) begin
            msg_kind = MSG_CONNECT;
          end else if (pings_q == '0) begin
            if (stats_q) begin
              msg_kind = MSG_STATS;
            end else begin
              msg_kind  = MSG_DISCONNECT;
              running_d = 1'b0;
            end
          end else begin
            msg_kind = MSG_PING;
            pings_d  = pings_q - 1'b1;
            plen     = payload_size_q;
          end
        end
      end
      MODE_NONE: begin
      end
    endcase
  end

  always_comb begin
    result_o.msg_valid         = msg_valid;
    result_o.msg_kind          = msg_kind;
    result_o.msg_id            = msg_id;
    result_o.ack_bits          = 32'(win_d);
    result_o.latest_seen_id    = latest_d;
    result_o.payload_length    = plen;
    result_o.session_running   = running_d;
    result_o.session_connected = connected_d;
    result_o.sent_total        = sent_d;
    result_o.received_total    = recv_d;
    result_o.dropped_total     = drop_d;
    result_o.late_total        = late_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_count_q   <= '0;
      payload_size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PING_COUNT:   ping_count_q   <= cfg_data_i[CntW-1:0];
        CFG_PAYLOAD_SIZE: payload_size_q <= cfg_data_i[PayW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      connected_q <= 1'b0;
      stats_q     <= 1'b1;
      pings_q     <= '0;
      next_id_q   <= '0;
      latest_q    <= '0;
      win_q       <= '0;
      sent_q      <= '0;
      recv_q      <= '0;
      drop_q      <= '0;
      late_q      <= '0;
    end else if (fire_i) begin
      running_q   <= running_d;
      connected_q <= connected_d;
      stats_q     <= stats_d;
      pings_q     <= pings_d;
      next_id_q   <= next_id_d;
      latest_q    <= latest_d;
      win_q       <= win_d;
      sent_q      <= sent_d;
      recv_q      <= recv_d;
      drop_q      <= drop_d;
      late_q      <= late_d;
    end
  end

endmodule

[hw/rtl/session_sequencer_ack_window.sv]
// Top level of the client session sequencer with sliding ack window.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | mode, server_kind, verdict_ok, server_msg_id
//  out     | source    | out_valid_o/out_stall_i | msg_*, ack_bits, status, four counters
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low. An item is held in the
// input register, then the window/counter logic updates the session state and
// loads the result register, which drives out_valid_o and the result outputs.
// Reset (async, active low) clears state; no clearing pass is needed.
// A stalled result register holds the item in the input register; in_stall_o
// rises only when both registers are full and out_stall_i is high.
// cfg_ready_o is always high; writes are meant for idle periods only.
module session_sequencer_ack_window import ssaw_pkg::*; #(
  parameter int unsigned WindowBits = DefWindowBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [1:0]          server_kind_i,
  input  logic                verdict_ok_i,
  input  logic [IdW-1:0]      server_msg_id_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                msg_valid_o,
  output logic [1:0]          msg_kind_o,
  output logic [IdW-1:0]      msg_id_o,
  output logic [31:0]         ack_bits_o,
  output logic [IdW-1:0]      latest_seen_id_o,
  output logic [PayW-1:0]     payload_length_o,
  output logic                session_running_o,
  output logic                session_connected_o,
  output logic [CntW-1:0]     sent_total_o,
  output logic [CntW-1:0]     received_total_o,
  output logic [CntW-1:0]     dropped_total_o,
  output logic [CntW-1:0]     late_total_o,
  // config writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_vld_q, in_vld_d;
  item_t   item_q;
  logic    out_vld_q, out_vld_d;
  result_t res_q, res_d;
  logic    in_take, fire;

  // stage 2 advances when the result register is empty or draining
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode          <= mode_e'(mode_i);
      item_q.server_kind   <= srv_kind_e'(server_kind_i);
      item_q.verdict_ok    <= verdict_ok_i;
      item_q.server_msg_id <= server_msg_id_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  ssaw_core #(.WindowBits(WindowBits)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .result_o   (res_d)
  );

  assign out_valid_o         = out_vld_q;
  assign msg_valid_o         = res_q.msg_valid;
  assign msg_kind_o          = res_q.msg_kind;
  assign msg_id_o            = res_q.msg_id;
  assign ack_bits_o          = res_q.ack_bits;
  assign latest_seen_id_o    = res_q.latest_seen_id;
  assign payload_length_o    = res_q.payload_length;
  assign session_running_o   = res_q.session_running;
  assign session_connected_o = res_q.session_connected;
  assign sent_total_o        = res_q.sent_total;
  assign received_total_o    = res_q.received_total;
  assign dropped_total_o     = res_q.dropped_total;
  assign late_total_o        = res_q.late_total;

endmodule

[hw/rtl/ssaw_checker.sv]
// Port-level checks for the session sequencer, bound to the top level.
module ssaw_checker import ssaw_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            msg_valid_o,
  input logic [1:0]      msg_kind_o,
  input logic [IdW-1:0]  msg_id_o,
  input logic [PayW-1:0] payload_length_o,
  input logic            session_connected_o,
  input logic [CntW-1:0] sent_total_o
);

  // held result must not change under stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(msg_id_o) && $stable(sent_total_o))
    else $error("result changed while stalled");

  // input side only backs up behind a full, stalled result register
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // no message: message fields read zero
  a_no_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !msg_valid_o |->
      msg_kind_o == MSG_CONNECT && msg_id_o == '0 && payload_length_o == '0)
    else $error("message fields set without a message");

  // ids and sent count advance together since the last start
  a_id_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_valid_o |-> msg_id_o == sent_total_o - 1'b1)
    else $error("message id out of step with sent count");

  // connect goes out only while not connected
  a_connect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_valid_o && msg_kind_o == MSG_CONNECT |-> !session_connected_o)
    else $error("connect sent while connected");

endmodule

bind session_sequencer_ack_window ssaw_checker u_ssaw_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .msg_valid_o         (msg_valid_o),
  .msg_kind_o          (msg_kind_o),
  .msg_id_o            (msg_id_o),
  .payload_length_o    (payload_length_o),
  .session_connected_o (session_connected_o),
  .sent_total_o        (sent_total_o)
);

[dv/session_sequencer_ack_window_test.sv]
// Self-checking testbench for the session sequencer with sliding ack window.
`timescale 1ns / 100ps

module session_sequencer_ack_window_test;
  import ssaw_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemBudget    = 800;
  // past this many items both sides run without idling
  localparam int unsigned CalmAfter     = 650;
  localparam longint      Win           = longint'(DefWindowBits);
  localparam logic [63:0] WinMask       = ~64'd0 >> (64 - DefWindowBits);

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    item_t   ev;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [1:0]          ev_mode = '0;
  logic [1:0]          ev_kind = '0;
  logic                ev_ok = 1'b0;
  logic [IdW-1:0]      ev_id = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic                msg_valid_o;
  logic [1:0]          msg_kind_o;
  logic [IdW-1:0]      msg_id_o;
  logic [31:0]         ack_bits_o;
  logic [IdW-1:0]      latest_seen_id_o;
  logic [PayW-1:0]     payload_length_o;
  logic                session_running_o;
  logic                session_connected_o;
  logic [CntW-1:0]     sent_total_o;
  logic [CntW-1:0]     received_total_o;
  logic [CntW-1:0]     dropped_total_o;
  logic [CntW-1:0]     late_total_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  session_sequencer_ack_window uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .mode_i              (ev_mode),
    .server_kind_i       (ev_kind),
    .verdict_ok_i        (ev_ok),
    .server_msg_id_i     (ev_id),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .msg_valid_o         (msg_valid_o),
    .msg_kind_o          (msg_kind_o),
    .msg_id_o            (msg_id_o),
    .ack_bits_o          (ack_bits_o),
    .latest_seen_id_o    (latest_seen_id_o),
    .payload_length_o    (payload_length_o),
    .session_running_o   (session_running_o),
    .session_connected_o (session_connected_o),
    .sent_total_o        (sent_total_o),
    .received_total_o    (received_total_o),
    .dropped_total_o     (dropped_total_o),
    .late_total_o        (late_total_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted session state and register copies
  // ---------------------------------------------------------------------------
  logic [31:0]   c_ping_count = '0;
  logic [15:0]   c_payload = '0;
  logic          s_running = 1'b0;
  logic          s_connected = 1'b0;
  logic          s_stats_due = 1'b1;
  logic [31:0]   s_pings_left = '0;
  logic [31:0]   s_next_id = '0;
  logic [31:0]   s_latest = '0;
  logic [63:0]   s_window = '0;
  logic [31:0]   s_sent = '0;
  logic [31:0]   s_recv = '0;
  logic [31:0]   s_drop = '0;
  logic [31:0]   s_late = '0;

  result_t       status_due[$];   // status items still owed by the block
  int unsigned   items_sent = 0;
  int unsigned   errors = 0;
  int unsigned   quiet = 0;
  bit            idle_on = 1'b0;
  int unsigned   stall_left = 0;

  // Advance the session by one event and return the status it reports.
  task automatic compute_session_status(input item_t it, output result_t r);
    logic [31:0] diff;
    longint      d;
    longint      top;
    logic [63:0] gone;
    bit          count;
    r = '0;
    case (it.mode)
      MODE_START: begin
        s_pings_left = c_ping_count;
        s_connected  = 1'b0;
        s_latest     = '0;
        s_window     = WinMask;
        s_next_id    = '0;
        s_sent       = '0;
        s_recv       = '0;
        s_drop       = '0;
        s_late       = '0;
        s_stats_due  = 1'b1;
        s_running    = 1'b1;
      end
      MODE_SERVER: begin
        count = 1'b1;
        case (it.server_kind)
          SRV_VERDICT: begin
            if (!it.verdict_ok) begin
              s_running = 1'b0;
              count     = 1'b0;
            end else begin
              s_connected = 1'b1;
            end
          end
          SRV_DISCONNECT: begin
            s_running   = 1'b0;
            s_connected = 1'b0;
            count       = 1'b0;
          end
          SRV_STATS: s_stats_due = 1'b0;
          default: ;
        endcase
        if (count) begin
          diff = it.server_msg_id - s_latest;
          d    = longint'($signed(diff));
          s_recv++;
          if (d < 0) begin
            s_late++;
            if (-d <= Win) s_window |= 64'd1 << (-d - 1);
          end else if (d > 0) begin
            // zero bits pushed out the top are lost ids, so is any gap past the window
            top    = (d < Win) ? d : Win;
            gone   = (s_window & WinMask) >> (Win - top);
            s_drop = s_drop + 32'(top) - 32'($countones(gone));
            if (d - 1 > Win) s_drop = s_drop + 32'(d - 1 - Win);
            s_latest = it.server_msg_id;
            if (d >= Win) s_window = '0;
            else s_window = (s_window << d) & WinMask;
            if (d - 1 < Win) s_window |= 64'd1 << (d - 1);
          end
        end
      end
      MODE_SEND: begin
        if (s_running) begin
          r.msg_valid = 1'b1;
          r.msg_id    = s_next_id;
          s_next_id++;
          s_sent++;
          if (!s_connected) begin
            r.msg_kind = MSG_CONNECT;
          end else if (s_pings_left == 0) begin
            if (s_stats_due) begin
              r.msg_kind = MSG_STATS;
            end else begin
              s_running  = 1'b0;
              r.msg_kind = MSG_DISCONNECT;
            end
          end else begin
            s_pings_left--;
            r.msg_kind       = MSG_PING;
            r.payload_length = c_payload;
          end
        end
      end
      default: ;
    endcase
    r.ack_bits          = s_window[31:0];
    r.latest_seen_id    = s_latest;
    r.session_running   = s_running;
    r.session_connected = s_connected;
    r.sent_total        = s_sent;
    r.received_total    = s_recv;
    r.dropped_total     = s_drop;
    r.late_total        = s_late;
  endtask

  function automatic item_t mk_event(mode_e m, srv_kind_e k, logic ok, logic [31:0] id);
    item_t e;
    e.mode          = m;
    e.server_kind   = k;
    e.verdict_ok    = ok;
    e.server_msg_id = id;
    return e;
  endfunction

  // status with no message and cleared counters
  function automatic result_t bare_status(logic run, logic [31:0] ack);
    result_t r;
    r                 = '0;
    r.session_running = run;
    r.ack_bits        = ack;
    return r;
  endfunction

  function automatic item_t noise_event();
    return mk_event(mode_e'($urandom_range(0, 3)), srv_kind_e'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), $urandom);
  endfunction

  // id close to the latest one, with window edges and far jumps mixed in
  function automatic logic [31:0] near_latest();
    int pick;
    int d;
    pick = $urandom_range(0, 99);
    if (pick < 60) d = int'($urandom_range(0, 80)) - 40;
    else if (pick < 75) return $urandom;
    else if (pick < 90) begin
      case ($urandom_range(0, 5))
        0: d = -33;
        1: d = -32;
        2: d = 32;
        3: d = 33;
        4: d = 34;
        default: d = 1;
      endcase
    end else d = 0;
    return s_latest + 32'(d);
  endfunction

  // Drive one item, wait for it to be taken, then predict its status.
  task automatic push_event(input item_t it, input bit typed, input result_t want);
    result_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ev_mode  <= it.mode;
    ev_kind  <= it.server_kind;
    ev_ok    <= it.verdict_ok;
    ev_id    <= it.server_msg_id;
    do @(posedge clk); while (in_stall_o);
    compute_session_status(it, r);
    status_due.insert(status_due.size(), typed ? want : r);
    items_sent++;
  endtask

  // Sender holds off until every owed status has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] ping, input logic [15:0] pay);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PING_COUNT;
    cfg_data  <= ping;
    do @(posedge clk); while (!cfg_ready_o);
    c_ping_count = ping;
    cfg_index <= CFG_PAYLOAD_SIZE;
    cfg_data  <= 32'(pay);
    do @(posedge clk); while (!cfg_ready_o);
    c_payload = pay;
    cfg_valid <= 1'b0;
  endtask

  // One experiment: start, verdict, then a mix of sends and server traffic.
  task automatic run_session();
    item_t e;
    int    n;
    int    pick;
    e      = noise_event();
    e.mode = MODE_START;
    push_event(e, 1'b0, '0);
    e             = noise_event();
    e.mode        = MODE_SERVER;
    e.server_kind = SRV_VERDICT;
    e.verdict_ok  = ($urandom_range(0, 99) < 85);
    e.server_msg_id = near_latest();
    push_event(e, 1'b0, '0);
    n = $urandom_range(8, 40);
    repeat (n) begin
      e    = noise_event();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        e.mode = MODE_SEND;
      end else if (pick < 80) begin
        e.mode        = MODE_SERVER;
        e.server_kind = (pick < 70) ? SRV_PONG : SRV_STATS;
        e.server_msg_id = near_latest();
      end else if (pick < 86) begin
        e.mode        = MODE_SERVER;
        e.server_kind = SRV_VERDICT;
        e.verdict_ok  = 1'b1;
        e.server_msg_id = near_latest();
      end else if (pick < 88) begin
        // session killers: server disconnect or a refused verdict
        e.mode = MODE_SERVER;
        e.server_kind = ($urandom_range(0, 1) != 0) ? SRV_DISCONNECT : SRV_VERDICT;
        e.verdict_ok  = 1'b0;
      end
      push_event(e, 1'b0, '0);
      if ($urandom_range(0, 199) == 0) hold_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts while idling is on
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every accepted status item is matched against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected status item, expected none actual ack %h", $time,
                 ack_bits_o);
        errors++;
      end else begin
        want = status_due.pop_front();
        check_field("msg_valid", 32'(want.msg_valid), 32'(msg_valid_o));
        check_field("msg_kind", 32'(want.msg_kind), 32'(msg_kind_o));
        check_field("msg_id", want.msg_id, msg_id_o);
        check_field("ack_bits", want.ack_bits, ack_bits_o);
        check_field("latest_seen_id", want.latest_seen_id, latest_seen_id_o);
        check_field("payload_length", 32'(want.payload_length), 32'(payload_length_o));
        check_field("session_running", 32'(want.session_running), 32'(session_running_o));
        check_field("session_connected", 32'(want.session_connected),
                    32'(session_connected_o));
        check_field("sent_total", want.sent_total, sent_total_o);
        check_field("received_total", want.received_total, received_total_o);
        check_field("dropped_total", want.dropped_total, dropped_total_o);
        check_field("late_total", want.late_total, late_total_o);
      end
    end
  end

  // Watchdog: counts cycles in which no handshake of any channel completes.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= WatchdogLimit);
    $display("%0t: watchdog expired with %0d status items owed", $time, status_due.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    plan[$];
    result_t     t;
    logic [31:0] ping;
    logic [15:0] pay;

    // stopped after reset: sends and the unused mode give a bare status
    plan.insert(plan.size(), '{mk_event(MODE_SEND, SRV_VERDICT, 1'b0, 32'h0), 1'b1,
                               bare_status(1'b0, '0)});
    plan.insert(plan.size(), '{mk_event(MODE_NONE, SRV_STATS, 1'b1, 32'hFFFF_FFFF), 1'b1,
                               bare_status(1'b0, '0)});
    plan.insert(plan.size(), '{mk_event(MODE_START, SRV_PONG, 1'b1, 32'hFFFF_FFFF), 1'b1,
                               bare_status(1'b1, '1)});
    t = bare_status(1'b1, '1);
    t.msg_valid  = 1'b1;
    t.msg_kind   = MSG_CONNECT;
    t.sent_total = 1;
    plan.insert(plan.size(),
                '{mk_event(MODE_SEND, SRV_DISCONNECT, 1'b1, 32'h5555_5555), 1'b1, t});
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_VERDICT, 1'b1, 32'h1), 1'b0, '0});
    // duplicate of latest
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_PONG, 1'b0, 32'h1), 1'b0, '0});
    plan.insert(plan.size(),
                '{mk_event(MODE_SEND, SRV_PONG, 1'b0, 32'hAAAA_AAAA), 1'b0, '0});
    // late inside the window, then a jump just past it
    plan.insert(plan.size(),
                '{mk_event(MODE_SERVER, SRV_PONG, 1'b1, 32'hFFFF_FFFF), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_PONG, 1'b0, 32'd34), 1'b0, '0});
    // late at the window edge, then one past it
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_PONG, 1'b0, 32'd2), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_PONG, 1'b0, 32'd1), 1'b0, '0});
    // largest forward step, then the most negative distance
    plan.insert(plan.size(),
                '{mk_event(MODE_SERVER, SRV_PONG, 1'b0, 32'h8000_0021), 1'b0, '0});
    plan.insert(plan.size(),
                '{mk_event(MODE_SERVER, SRV_PONG, 1'b1, 32'h0000_0021), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SEND, SRV_STATS, 1'b1, 32'h0), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SEND, SRV_VERDICT, 1'b0, 32'h0), 1'b0, '0});
    plan.insert(plan.size(),
                '{mk_event(MODE_SERVER, SRV_STATS, 1'b0, 32'h8000_0022), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SEND, SRV_PONG, 1'b1, 32'h0), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SEND, SRV_PONG, 1'b1, 32'h0), 1'b0, '0});
    // server traffic still counts while stopped
    plan.insert(plan.size(),
                '{mk_event(MODE_SERVER, SRV_PONG, 1'b1, 32'h8000_0030), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_START, SRV_VERDICT, 1'b0, 32'h0), 1'b1,
                               bare_status(1'b1, '1)});
    // refused verdict stops before counting
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_VERDICT, 1'b0, 32'd7), 1'b1,
                               bare_status(1'b0, '1)});
    plan.insert(plan.size(), '{mk_event(MODE_START, SRV_DISCONNECT, 1'b0, 32'h0), 1'b1,
                               bare_status(1'b1, '1)});
    // server disconnect stops before counting
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_DISCONNECT, 1'b1, 32'd5), 1'b1,
                               bare_status(1'b0, '1)});
    plan.insert(plan.size(), '{mk_event(MODE_START, SRV_PONG, 1'b0, 32'h0), 1'b0, '0});
    plan.insert(plan.size(), '{mk_event(MODE_SERVER, SRV_VERDICT, 1'b1, 32'h0), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_regs(32'd2, 16'hFFFF);
    idle_on = 1'b1;
    foreach (plan[i]) push_event(plan[i].ev, plan[i].typed, plan[i].want);

    // random sessions, registers rewritten between them while drained
    while (items_sent < ItemBudget) begin
      hold_until_drained();
      case ($urandom_range(0, 9))
        0: ping = '0;
        1: ping = '1;
        2: ping = $urandom;
        default: ping = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 3))
        0: pay = '0;
        1: pay = '1;
        default: pay = 16'($urandom);
      endcase
      program_regs(ping, pay);
      idle_on = (items_sent < CalmAfter) && ($urandom_range(0, 3) != 0);
      run_session();
    end

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (errors == 0 && status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
